/* design/fqd_pkg.sv */
package fqd_pkg;

  // Queue geometry
  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int HANDLE_W = 32;
  localparam int LEN_W = 5;

  // Command codes
  localparam logic [1:0] CMD_ENQUEUE = 2'd0;
  localparam logic [1:0] CMD_DEQUEUE = 2'd1;
  localparam logic [1:0] CMD_DELETE  = 2'd2;

  // Result status codes
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_REFUSED = 1'b1;

  typedef logic [HANDLE_W-1:0] handle_t;

  // Command beat
  typedef struct packed {
    logic [1:0] command;
    handle_t    item_handle;
  } in_t;

  // Response beat
  typedef struct packed {
    logic             status;
    handle_t          out_handle;
    logic [LEN_W-1:0] length;
  } out_t;

  // Broadcast controls for the cell row, already qualified by accept
  typedef struct packed {
    logic    enq;
    logic    deq;
    logic    del;
    handle_t handle;
  } cell_ctl_t;

endpackage

/* design/fifo_queue_with_delete_core.sv */
// The response is captured in the output register at the edge that accepts its command beat.
// Throughput: one command per cycle while responses are taken; the cell row settles
//   enqueue, dequeue or delete with gap closing in its next-state logic. A response left
//   waiting holds off the next command until the cycle in which it is taken.
// Reset (synchronous, active high) clears the cell valid bits, the entry count and
//   the response valid; entry payloads are not cleared.
module fifo_queue_with_delete_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  fqd_pkg::in_t  cmd,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output fqd_pkg::out_t rsp
);
  import fqd_pkg::*;

  logic                  accept;
  logic                  handle_nz;
  cell_ctl_t             ctl;
  logic [DEPTH-1:0]      cell_valid;
  logic [DEPTH-1:0]      cell_found;
  handle_t               cell_data [DEPTH];
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;
  logic                  enq_ok;
  logic                  deq_ok;
  logic                  del_ok;
  out_t                  rsp_next;

  // Handshake: the response register parts the two sides
  assign cmd_ready = !rsp_valid || rsp_ready;
  assign accept    = cmd_valid && cmd_ready;
  assign handle_nz = (cmd.item_handle != '0);

  // Controls broadcast to every cell
  always_comb begin
    ctl.enq    = accept && (cmd.command == CMD_ENQUEUE) && handle_nz;
    ctl.deq    = accept && (cmd.command == CMD_DEQUEUE);
    ctl.del    = accept && (cmd.command == CMD_DELETE) && handle_nz;
    ctl.handle = cmd.item_handle;
  end

  // Row of cells, entry 0 is the oldest
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic    prev_v;
    logic    f_in;
    logic    nxt_v;
    handle_t nxt_d;
    if (i == 0) begin : g_head
      assign prev_v = 1'b1;
      assign f_in   = 1'b0;
    end else begin : g_body
      assign prev_v = cell_valid[i-1];
      assign f_in   = cell_found[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign nxt_v = 1'b0;
      assign nxt_d = '0;
    end else begin : g_mid
      assign nxt_v = cell_valid[i+1];
      assign nxt_d = cell_data[i+1];
    end
    fqd_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .prev_valid (prev_v),
      .found_in   (f_in),
      .next_valid (nxt_v),
      .next_data  (nxt_d),
      .valid      (cell_valid[i]),
      .data       (cell_data[i]),
      .found_out  (cell_found[i])
    );
  end

  // Outcome of the command
  assign enq_ok = ctl.enq && !cell_valid[DEPTH-1];
  assign deq_ok = ctl.deq && cell_valid[0];
  assign del_ok = ctl.del && cell_found[DEPTH-1];

  always_comb begin
    count_next = count;
    if (enq_ok) begin
      count_next = count + CNT_W'(1);
    end else if (deq_ok || del_ok) begin
      count_next = count - CNT_W'(1);
    end
  end

  // Response payload
  always_comb begin
    rsp_next.status     = (enq_ok || deq_ok || del_ok) ? STATUS_OK : STATUS_REFUSED;
    rsp_next.out_handle = deq_ok ? cell_data[0] : '0;
    rsp_next.length     = LEN_W'(count_next);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        count <= count_next;
      end
      if (accept) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

  // Entry count tracks the occupied cells
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    $countones(cell_valid) == 32'(count))
    else $error("entry count differs from occupied cells");

  // When the tail cell is occupied, every cell is occupied (no gap)
  a_packed: assert property (@(posedge clk) disable iff (rst)
    cell_valid[DEPTH-1] |-> (&cell_valid))
    else $error("gap in occupied cells");

  // A successful enqueue grows the queue by one
  a_enq_grows: assert property (@(posedge clk) disable iff (rst)
    enq_ok |=> (count == $past(count) + CNT_W'(1)))
    else $error("enqueue did not grow the queue");

  // A delete that succeeds reports one entry fewer
  a_del_len: assert property (@(posedge clk) disable iff (rst)
    del_ok |=> (rsp_valid && rsp.status == STATUS_OK
                && rsp.length == LEN_W'($past(count) - CNT_W'(1))))
    else $error("delete response length wrong");

endmodule

/* design/fqd_cell.sv */
module fqd_cell (
  input  logic               clk,
  input  logic               rst,
  input  fqd_pkg::cell_ctl_t ctl,
  input  logic               prev_valid,
  input  logic               found_in,
  input  logic               next_valid,
  input  fqd_pkg::handle_t   next_data,
  output logic               valid,
  output fqd_pkg::handle_t   data,
  output logic               found_out
);
  import fqd_pkg::*;

  logic    match_here;
  logic    shift;
  logic    load;
  logic    valid_next;
  handle_t data_next;

  // Delete looks for the oldest match; the found flag ripples toward the tail
  assign match_here = ctl.del && valid && (data == ctl.handle);
  assign found_out  = found_in || match_here;

  // Dequeue shifts the whole row; delete shifts from the match onward
  assign shift = ctl.deq || (ctl.del && found_out);
  // Enqueue lands in the first empty cell
  assign load  = ctl.enq && !valid && prev_valid;

  always_comb begin
    valid_next = valid;
    data_next  = data;
    if (shift) begin
      valid_next = next_valid;
      data_next  = next_data;
    end else if (load) begin
      valid_next = 1'b1;
      data_next  = ctl.handle;
    end
  end

  // Occupancy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  // Entry payload, no reset needed
  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

/* bench/fifo_queue_with_delete_core_tb.sv */
module fifo_queue_with_delete_core_tb;
  import fqd_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT = 3000;
  localparam int RANDOM_ITEMS = 830;
  localparam int BURST_START = 300;
  localparam int BURST_LEN = 40;

  // Queue model plus the responses it predicts, oldest first
  class queue_scoreboard;
    handle_t held[$];
    out_t pending_rsp[$];
    int mismatches;

    function new();
      mismatches = 0;
    endfunction

    // Apply one accepted command beat to the model and queue its response
    function void note_command(in_t c);
      out_t r;
      int hit;
      r.status = STATUS_REFUSED;
      r.out_handle = '0;
      case (c.command)
        CMD_ENQUEUE: begin
          if (c.item_handle != '0 && held.size() < DEPTH) begin
            held.push_back(c.item_handle);
            r.status = STATUS_OK;
          end
        end
        CMD_DEQUEUE: begin
          if (held.size() > 0) begin
            r.out_handle = held.pop_front();
            r.status = STATUS_OK;
          end
        end
        CMD_DELETE: begin
          hit = -1;
          if (c.item_handle != '0) begin
            for (int i = 0; i < held.size(); i++) begin
              if (hit < 0 && held[i] == c.item_handle) hit = i;
            end
          end
          if (hit >= 0) begin
            held.delete(hit);
            r.status = STATUS_OK;
          end
        end
        default: ;
      endcase
      r.length = LEN_W'(held.size());
      pending_rsp.push_back(r);
    endfunction

    function void flag(string what, out_t want, out_t got);
      mismatches++;
      if (mismatches <= 10)
        $display("[%0t] %s: expected st=%0d h=%h len=%0d, got st=%0d h=%h len=%0d",
                 $time, what, want.status, want.out_handle, want.length,
                 got.status, got.out_handle, got.length);
    endfunction

    // Compare one accepted response beat against the oldest prediction
    function void check_response(out_t got);
      out_t want;
      if (pending_rsp.size() == 0) begin
        want = '0;
        flag("response with none pending", want, got);
      end else begin
        want = pending_rsp.pop_front();
        if (got.status !== want.status) flag("status", want, got);
        else if (got.out_handle !== want.out_handle) flag("out_handle", want, got);
        else if (got.length !== want.length) flag("length", want, got);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  in_t cmd = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  out_t rsp;

  queue_scoreboard sb;
  bit hold_req = 1'b0;
  int idle_cycles = 0;

  fifo_queue_with_delete_core DUT (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd(cmd),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Response side: check every accepted beat
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) sb.check_response(rsp);
  end

  // Cycles with no beat on either side
  always @(posedge clk) begin
    if (rst || (cmd_valid && cmd_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("end of test: mismatches");
    $finish;
  end

  // Receiver: ready runs and stalls, plus one long hold on request
  initial begin
    int left;
    bit level;
    int stall;
    left = 0;
    level = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        level = 1'b0;
        left = HOLD_CYCLES;
      end else if (left > 0) begin
        left--;
      end else if (level) begin
        stall = $urandom_range(0, 99);
        if (stall < 40) stall = 0;
        else if (stall < 90) stall = $urandom_range(1, 3);
        else stall = $urandom_range(15, 60);
        if (stall > 0) begin
          level = 1'b0;
          left = stall - 1;
        end else begin
          left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 100) : $urandom_range(1, 6);
        end
      end else begin
        level = 1'b1;
        left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 100) : $urandom_range(1, 6);
      end
      rsp_ready <= level;
    end
  end

  // Offer one command beat after an optional gap; returns at the accepting edge
  task automatic send(input logic [1:0] op, input handle_t h, input int gap);
    in_t c;
    c.command = op;
    c.item_handle = h;
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= c;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    sb.note_command(c);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Handles: deletes often reuse a held one; else mostly wide random, some small repeats, a few edges
  function automatic handle_t pick_handle(input logic [1:0] op);
    int r;
    if (op == CMD_DELETE && sb.held.size() > 0 && $urandom_range(0, 9) < 6)
      return sb.held[$urandom_range(0, sb.held.size() - 1)];
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r < 7) return handle_t'($urandom_range(1, 6));
    return $urandom;
  endfunction

  task automatic run_directed();
    send(CMD_DEQUEUE, 32'hFFFF_FFFF, 0);   // dequeue on empty
    send(CMD_DELETE, 32'd7, 0);            // delete on empty
    send(CMD_ENQUEUE, 32'd0, 0);           // null enqueue
    send(CMD_UNUSED, 32'hFFFF_FFFF, 0);
    send(CMD_ENQUEUE, 32'hFFFF_FFFF, 0);
    send(CMD_ENQUEUE, 32'd1, 0);
    send(CMD_ENQUEUE, 32'hFFFF_FFFF, 0);   // duplicate
    send(CMD_ENQUEUE, 32'h8000_0000, 0);
    send(CMD_DELETE, 32'd0, 0);            // null delete
    send(CMD_DELETE, 32'h1234_5678, 0);    // no match
    send(CMD_DELETE, 32'hFFFF_FFFF, 0);    // oldest of the duplicates goes
    send(CMD_UNUSED, 32'd1, 0);
    send(CMD_DEQUEUE, 32'h5A5A_5A5A, 0);   // operand ignored
    send(CMD_DELETE, 32'h8000_0000, 0);    // tail entry
    send(CMD_DEQUEUE, 32'd0, 0);
    send(CMD_DEQUEUE, 32'd0, 0);           // empty again
    send(CMD_ENQUEUE, 32'd2, 0);
    send(CMD_ENQUEUE, 32'd2, 0);
    send(CMD_DELETE, 32'd2, 0);
    send(CMD_DEQUEUE, 32'd0, 0);
  endtask

  // Random phases lean toward filling, draining or neither
  task automatic run_random();
    int mode;
    bit quiet;
    int r;
    int gap;
    logic [1:0] op;
    mode = 0;
    quiet = 1'b0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) begin
        mode = $urandom_range(0, 2);
        quiet = ($urandom_range(0, 3) == 0);
      end
      if (n == BURST_START) hold_req = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 3) op = CMD_UNUSED;
      else if (mode == 0) op = (r < 78) ? CMD_ENQUEUE : (r < 88) ? CMD_DEQUEUE : CMD_DELETE;
      else if (mode == 1) op = (r < 23) ? CMD_ENQUEUE : (r < 73) ? CMD_DEQUEUE : CMD_DELETE;
      else op = (r < 43) ? CMD_ENQUEUE : (r < 73) ? CMD_DEQUEUE : CMD_DELETE;
      if (quiet || (n >= BURST_START && n < BURST_START + BURST_LEN)) gap = 0;
      else gap = pick_gap();
      send(op, (op == CMD_DEQUEUE) ? handle_t'($urandom) : pick_handle(op), gap);
    end
  endtask

  // Main sequence
  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    run_random();
    cmd_valid <= 1'b0;
    while (sb.pending_rsp.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_rsp.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
